>>> rtl/lidar_return_to_cartesian_unit_defines.svh
// assertion macros shared by the lidar projection checkers
`ifndef LIDAR_RETURN_TO_CARTESIAN_UNIT_DEFINES_SVH
`define LIDAR_RETURN_TO_CARTESIAN_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LRC_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("lrc check failed");

// next-cycle implication, disabled during reset
`define LRC_ASSERT_NEXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("lrc check failed");

`endif

>>> rtl/lrc_pkg.sv
// shared types, constants and helper functions of the lidar projection unit
`default_nettype none
package lrc_pkg;

  localparam int PIXELS_DEF     = 128;
  localparam int ANGLE_BITS_DEF = 20;

  localparam int ADDR_W      = 4;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 96;

  localparam logic [1:0] REG_ENC_LOW    = 2'd0;
  localparam logic [1:0] REG_ENC_HIGH   = 2'd1;
  localparam logic [1:0] REG_MIN_RANGE  = 2'd2;
  localparam logic [1:0] REG_BEAM_OFFS  = 2'd3;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_PROJECT = 1'b1;

  localparam logic [16:0] ENC_LOW_RST  = 17'd0;
  localparam logic [16:0] ENC_HIGH_RST = 17'd90111;
  localparam logic [17:0] ENC_TURN     = 18'd90112;
  localparam logic [17:0] ENC_TURN2    = 18'd180224;
  localparam logic [17:0] ENC_RECIP    = 18'd190651;
  localparam int          ENC_RECIP_SH = 21;

  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam int          SIN_TOP = 6;
  localparam logic [31:0] SIN_COEF [7] = '{
    32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995,
    32'd172272, 32'd3864, 32'd61
  };

  localparam int CELL_SQUARE = 0;
  localparam int CELL_HORNER = 1;
  localparam int CELL_FINAL  = 2;

  localparam logic [29:0] INT_SCALE = 30'd1055439989;
  localparam logic [16:0] INT_BIAS  = 17'd100;

  typedef struct packed {
    logic [31:0] u;
    logic [31:0] u2;
    logic [31:0] acc;
    logic        neg;
  } sine_lane_t;

  typedef struct packed {
    logic [30:0] y;
    logic [28:0] res;
  } log_lane_t;

  function automatic logic [28:0] log2_q24_const(input int unsigned m);
    int unsigned     e;
    longint unsigned y;
    longint unsigned res;
    e = 0;
    while (e < 31 && (m >> (e + 1)) != 0) e++;
    y = longint'(m) << (30 - e);
    res = longint'(e) << 24;
    for (int k = 23; k >= 0; k--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        res = res | (64'd1 << k);
      end
    end
    return res[28:0];
  endfunction

  localparam logic [28:0] LG100 = log2_q24_const(100);

  // fractional phase of the encoder remainder, (rem * 2^19 + 5) / 11
  function automatic logic [18:0] enc_frac(input logic [3:0] rem);
    logic [18:0] f;
    case (rem)
      4'd0:    f = 19'd0;
      4'd1:    f = 19'd47663;
      4'd2:    f = 19'd95325;
      4'd3:    f = 19'd142988;
      4'd4:    f = 19'd190650;
      4'd5:    f = 19'd238313;
      4'd6:    f = 19'd285975;
      4'd7:    f = 19'd333638;
      4'd8:    f = 19'd381300;
      4'd9:    f = 19'd428963;
      4'd10:   f = 19'd476625;
      default: f = 19'd0;
    endcase
    return f;
  endfunction

  function automatic logic [21:0] sat22(input logic signed [63:0] v);
    logic [21:0] o;
    if (v > 64'sd2097151) o = 22'h1F_FFFF;
    else if (v < -64'sd2097152) o = 22'h20_0000;
    else o = v[21:0];
    return o;
  endfunction

endpackage
`default_nettype wire

>>> rtl/lrc_sine_cell.sv
// one step of the quarter-wave sine polynomial, registered
`default_nettype none
module lrc_sine_cell #(
  parameter int MODE     = lrc_pkg::CELL_HORNER,
  parameter int COEF_IDX = 0
) (
  input  wire                 clk,
  input  wire                 en,
  input  lrc_pkg::sine_lane_t lane_i,
  output lrc_pkg::sine_lane_t lane_o
);
  import lrc_pkg::*;

  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [63:0] rnd;
  logic [31:0] qm;
  sine_lane_t  nxt;

  always_comb begin
    op_a = (MODE == CELL_HORNER) ? lane_i.u2 : lane_i.u;
    op_b = (MODE == CELL_SQUARE) ? lane_i.u : lane_i.acc;
    prod = 64'(op_a) * 64'(op_b);
    rnd  = prod + (64'd1 << 29);
    qm   = rnd[61:30];
    nxt  = lane_i;
    case (MODE)
      CELL_SQUARE: begin
        nxt.u2  = qm;
        nxt.acc = SIN_COEF[SIN_TOP];
      end
      CELL_HORNER: nxt.acc = SIN_COEF[COEF_IDX] - qm;
      CELL_FINAL:  nxt.acc = (qm > Q30_ONE) ? Q30_ONE : qm;
      default:     nxt = lane_i;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) lane_o <= nxt;
  end

endmodule
`default_nettype wire

>>> rtl/lrc_log_cell.sv
// one squaring step of the log2 fraction, yields one result bit
`default_nettype none
module lrc_log_cell #(
  parameter int BIT_POS = 0
) (
  input  wire                clk,
  input  wire                en,
  input  lrc_pkg::log_lane_t lane_i,
  output lrc_pkg::log_lane_t lane_o
);
  import lrc_pkg::*;

  logic [61:0] sq;
  logic [31:0] t;
  log_lane_t   nxt;

  always_comb begin
    sq  = 62'(lane_i.y) * 62'(lane_i.y);
    t   = sq[61:30];
    nxt = lane_i;
    if (t[31]) begin
      nxt.y = t[31:1];
      nxt.res[BIT_POS] = 1'b1;
    end else begin
      nxt.y = t[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) lane_o <= nxt;
  end

endmodule
`default_nettype wire

>>> rtl/lidar_return_to_cartesian_unit.sv
// top level: lidar return to cartesian point projection pipeline
// input stream s_*: tuser carries cmd, tdata the return or beam fields.
// cmd load writes one beam's altitude and azimuth into the angle memories;
// cmd project sends one return down a 27-stage pipeline that yields x, y, z
// in mm, the normalized intensity and the pixel index on m_*.
// returns outside the encoder window, below min_range or with a pixel beyond
// the table are dropped at the input and give no word.
// one word is taken per cycle while m_tready does not stall the output.
// the pipeline depth is set by the intensity path: 24 squaring cells of the log2
// fraction, plus input, scaling and output stages. the sine path is a row of
// 8 polynomial cells running six lanes side by side.
// each stage moves when it is empty or the stage after it moves, so a stalled
// m_tready fills the pipeline bubbles first; s_tready drops only when every
// stage holds a word.
// reset clears the pipeline valids and the four apb registers; the angle
// memories are not cleared and must be loaded before a pixel is projected.
// apb: registers at byte addresses 0, 4, 8, 12, written in the access phase.
`default_nettype none
module lidar_return_to_cartesian_unit #(
  parameter int PIXELS     = lrc_pkg::PIXELS_DEF,
  parameter int ANGLE_BITS = lrc_pkg::ANGLE_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // pixel_index, enc_count, range_value, intensity_value, altitude_angle,
  // azimuth_angle, zero pad
  input  wire  [lrc_pkg::IN_TDATA_W-1:0]    s_tdata,
  // cmd
  input  wire                               s_tuser,
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // point_x, point_y, point_z, norm_intensity, point_pixel, zero pad
  output logic [lrc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [lrc_pkg::ADDR_W-1:0]        paddr,
  input  wire  [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import lrc_pkg::*;

  localparam int LAT   = 27;
  localparam int IDX_W = $clog2(PIXELS);
  localparam logic [31:0] ANG_RND = 32'd1 << (31 - ANGLE_BITS);
  localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  // configuration
  logic [16:0] enc_low;
  logic [16:0] enc_high;
  logic [19:0] min_range;
  logic [15:0] beam_offset;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_low     <= ENC_LOW_RST;
      enc_high    <= ENC_HIGH_RST;
      min_range   <= '0;
      beam_offset <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_ENC_LOW:   enc_low     <= pwdata[16:0];
        REG_ENC_HIGH:  enc_high    <= pwdata[16:0];
        REG_MIN_RANGE: min_range   <= pwdata[19:0];
        REG_BEAM_OFFS: beam_offset <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ENC_LOW:   prdata = {15'd0, enc_low};
      REG_ENC_HIGH:  prdata = {15'd0, enc_high};
      REG_MIN_RANGE: prdata = {12'd0, min_range};
      REG_BEAM_OFFS: prdata = {16'd0, beam_offset};
      default:       prdata = '0;
    endcase
  end

  // input fields
  logic [6:0]  in_pix;
  logic [16:0] in_enc;
  logic [19:0] in_rng;
  logic [15:0] in_int;
  logic [19:0] in_alt;
  logic [19:0] in_az;

  assign in_pix = s_tdata[6:0];
  assign in_enc = s_tdata[23:7];
  assign in_rng = s_tdata[43:24];
  assign in_int = s_tdata[59:44];
  assign in_alt = s_tdata[79:60];
  assign in_az  = s_tdata[99:80];

  // stage valids and enables
  logic [LAT:1] v;
  logic [LAT:1] en;

  assign en[LAT] = ~v[LAT] | m_tready;
  for (genvar k = 1; k < LAT; k++) begin : g_en
    assign en[k] = ~v[k] | en[k+1];
  end

  assign s_tready = en[1];
  assign m_tvalid = v[LAT];

  logic pix_ok;
  logic keep;
  logic accept;

  assign pix_ok = 32'(in_pix) < PIXELS;
  assign accept = s_tvalid & en[1];
  assign keep   = (s_tuser == CMD_PROJECT) & pix_ok & (in_enc >= enc_low) &
                  (in_enc <= enc_high) & (in_rng >= min_range);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_tvalid & keep;
      for (int k = 2; k <= LAT; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // beam angle memories
  logic [19:0] alt_mem [PIXELS];
  logic [19:0] az_mem  [PIXELS];
  logic [19:0] alt1, alt2, alt3;
  logic [19:0] az1, az2, az3;

  always_ff @(posedge clk) begin
    if (accept && s_tuser == CMD_LOAD && pix_ok) begin
      alt_mem[in_pix[IDX_W-1:0]] <= in_alt;
      az_mem[in_pix[IDX_W-1:0]]  <= in_az;
    end
    if (en[1]) begin
      alt1 <= alt_mem[in_pix[IDX_W-1:0]];
      az1  <= az_mem[in_pix[IDX_W-1:0]];
    end
  end

  // stage 1: encoder distance, range, log normalization
  logic [17:0]        d_full;
  logic [16:0]        d_c;
  logic [16:0]        d1;
  logic [34:0]        qp1;
  logic signed [26:0] r_c;
  logic [16:0]        m_c;
  logic [4:0]         e_c;
  log_lane_t          ll [0:24];
  log_lane_t          ll_c;

  always_comb begin
    d_full = ({1'b0, in_enc} <= ENC_TURN) ? ENC_TURN - {1'b0, in_enc}
                                          : ENC_TURN2 - {1'b0, in_enc};
    d_c  = (d_full == ENC_TURN) ? 17'd0 : d_full[16:0];
    r_c  = $signed({1'b0, in_rng, 6'd0}) - $signed({11'd0, beam_offset});
    m_c  = {1'b0, in_int} + INT_BIAS;
    e_c  = '0;
    for (int b = 0; b < 17; b++) begin
      if (m_c[b]) e_c = 5'(b);
    end
    ll_c.y   = 31'(m_c) << (5'd30 - e_c);
    ll_c.res = {e_c, 24'd0};
  end

  logic [6:0]         pix_d [1:LAT];
  logic signed [26:0] r_d   [1:14];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1       <= d_c;
      qp1      <= 35'(d_c) * 35'(ENC_RECIP);
      r_d[1]   <= r_c;
      pix_d[1] <= in_pix;
      ll[0]    <= ll_c;
    end
  end

  for (genvar k = 2; k <= LAT; k++) begin : g_pix
    always_ff @(posedge clk) begin
      if (en[k]) pix_d[k] <= pix_d[k-1];
    end
  end

  for (genvar k = 2; k <= 14; k++) begin : g_rng
    always_ff @(posedge clk) begin
      if (en[k]) r_d[k] <= r_d[k-1];
    end
  end

  // stages 2 to 4: encoder phase and angle rounding
  logic [12:0] q_c;
  logic [16:0] q11_c;
  logic [16:0] rem_c;
  logic [12:0] q2;
  logic [3:0]  rem2;
  logic [31:0] ph3;
  logic [ANGLE_BITS-1:0] ang_alt4, ang_sum4, ang_enc4;

  function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [31:0] ph);
    logic [31:0] s;
    s = ph + ANG_RND;
    return s[31:32-ANGLE_BITS];
  endfunction

  assign q_c   = qp1[33:ENC_RECIP_SH];
  assign q11_c = ({4'd0, q_c} << 3) + ({4'd0, q_c} << 1) + {4'd0, q_c};
  assign rem_c = d1 - q11_c;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q2   <= q_c;
      rem2 <= rem_c[3:0];
      alt2 <= alt1;
      az2  <= az1;
    end
    if (en[3]) begin
      ph3  <= {q2, 19'd0} + {13'd0, enc_frac(rem2)};
      alt3 <= alt2;
      az3  <= az2;
    end
    if (en[4]) begin
      ang_alt4 <= to_angle({alt3, 12'd0});
      ang_sum4 <= to_angle(ph3 + {az3, 12'd0});
      ang_enc4 <= to_angle(ph3);
    end
  end

  // stage 5: quadrant fold; lanes are sin/cos of altitude, sum, encoder
  function automatic sine_lane_t lane_prep(input logic [ANGLE_BITS-1:0] ang);
    logic [31:0] u;
    sine_lane_t  l;
    u = 32'(ang[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
    if (ang[ANGLE_BITS-2]) u = Q30_ONE - u;
    l.u   = u;
    l.u2  = '0;
    l.acc = '0;
    l.neg = ang[ANGLE_BITS-1];
    return l;
  endfunction

  sine_lane_t sl [0:8][0:5];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sl[0][0] <= lane_prep(ang_alt4);
      sl[0][1] <= lane_prep(ang_alt4 + QUARTER);
      sl[0][2] <= lane_prep(ang_sum4);
      sl[0][3] <= lane_prep(ang_sum4 + QUARTER);
      sl[0][4] <= lane_prep(ang_enc4);
      sl[0][5] <= lane_prep(ang_enc4 + QUARTER);
    end
  end

  // stages 6 to 13: polynomial cells
  for (genvar j = 0; j < 8; j++) begin : g_sin
    for (genvar l = 0; l < 6; l++) begin : g_lane
      lrc_sine_cell #(
        .MODE     ((j == 0) ? CELL_SQUARE : ((j == 7) ? CELL_FINAL : CELL_HORNER)),
        .COEF_IDX ((j == 0 || j == 7) ? 0 : SIN_TOP - j)
      ) u_cell (
        .clk    (clk),
        .en     (en[6+j]),
        .lane_i (sl[j][l]),
        .lane_o (sl[j+1][l])
      );
    end
  end

  // stages 2 to 25: log2 fraction cells
  for (genvar j = 0; j < 24; j++) begin : g_log
    lrc_log_cell #(
      .BIT_POS (23 - j)
    ) u_cell (
      .clk    (clk),
      .en     (en[2+j]),
      .lane_i (ll[j]),
      .lane_o (ll[j+1])
    );
  end

  // stages 14 to 18: sign, projection products, rounding
  logic signed [31:0] s14 [0:5];
  logic signed [31:0] cs15, ss15, ce15, se15;
  logic signed [31:0] cs16, ss16, ce16, se16;
  logic signed [58:0] tp15, zp15;
  logic signed [58:0] tr_c, zr_c;
  logic signed [28:0] t16;
  logic [21:0]        z_d [16:LAT];
  logic signed [60:0] xp17, yp17;
  logic signed [48:0] xo17, yo17;
  logic signed [63:0] xs_c, ys_c;
  logic [21:0]        x_d [18:LAT];
  logic [21:0]        y_d [18:LAT];

  assign tr_c = tp15 + (59'sd1 <<< 29);
  assign zr_c = zp15 + (59'sd1 <<< 35);
  assign xs_c = 64'(xp17) + 64'(xo17) + (64'sd1 <<< 35);
  assign ys_c = 64'(yp17) + 64'(yo17) + (64'sd1 <<< 35);

  always_ff @(posedge clk) begin
    if (en[14]) begin
      for (int l = 0; l < 6; l++) begin
        s14[l] <= sl[8][l].neg ? -$signed(sl[8][l].acc) : $signed(sl[8][l].acc);
      end
    end
    if (en[15]) begin
      tp15 <= r_d[14] * s14[1];
      zp15 <= r_d[14] * s14[0];
      ss15 <= s14[2];
      cs15 <= s14[3];
      se15 <= s14[4];
      ce15 <= s14[5];
    end
    if (en[16]) begin
      t16       <= tr_c[58:30];
      z_d[16]   <= sat22(64'(zr_c >>> 36));
      cs16      <= cs15;
      ss16      <= ss15;
      ce16      <= ce15;
      se16      <= se15;
    end
    if (en[17]) begin
      xp17    <= t16 * cs16;
      yp17    <= t16 * ss16;
      xo17    <= $signed({1'b0, beam_offset}) * ce16;
      yo17    <= $signed({1'b0, beam_offset}) * se16;
      z_d[17] <= z_d[16];
    end
    if (en[18]) begin
      x_d[18] <= sat22(xs_c >>> 36);
      y_d[18] <= sat22(ys_c >>> 36);
      z_d[18] <= z_d[17];
    end
  end

  for (genvar k = 19; k <= LAT; k++) begin : g_xyz
    always_ff @(posedge clk) begin
      if (en[k]) begin
        x_d[k] <= x_d[k-1];
        y_d[k] <= y_d[k-1];
        z_d[k] <= z_d[k-1];
      end
    end
  end

  // stages 26 and 27: intensity scaling
  logic signed [29:0] dl_c;
  logic               dpos26;
  logic [58:0]        dprod26;
  logic [59:0]        nr_c;
  logic [15:0]        norm27;

  assign dl_c = $signed({1'b0, ll[24].res}) - $signed({1'b0, LG100});
  assign nr_c = {1'b0, dprod26} + (60'd1 << 39);

  always_ff @(posedge clk) begin
    if (en[26]) begin
      dpos26  <= ~dl_c[29] & (dl_c != '0);
      dprod26 <= 59'(dl_c[28:0]) * 59'(INT_SCALE);
    end
    if (en[27]) begin
      if (!dpos26) norm27 <= '0;
      else if (nr_c[59:40] > 20'd65535) norm27 <= 16'hFFFF;
      else norm27 <= nr_c[55:40];
    end
  end

  assign m_tdata = {7'd0, pix_d[LAT], norm27, z_d[LAT], y_d[LAT], x_d[LAT]};

endmodule
`default_nettype wire

>>> rtl/lrc_checker.sv
// port-level checks of the lidar projection unit and their bind
`default_nettype none
`include "lidar_return_to_cartesian_unit_defines.svh"
module lrc_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             s_tready,
  input wire                             m_tvalid,
  input wire                             m_tready,
  input wire [lrc_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input wire                             psel,
  input wire                             penable,
  input wire                             pwrite,
  input wire [lrc_pkg::ADDR_W-1:0]       paddr,
  input wire [31:0]                      pwdata,
  input wire [31:0]                      prdata
);
  import lrc_pkg::*;

  logic wr_min;
  logic rd_other;

  assign wr_min   = psel && penable && pwrite && (paddr[3:2] == REG_MIN_RANGE);
  assign rd_other = (paddr[3:2] != REG_MIN_RANGE);

  `LRC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `LRC_ASSERT_IMP(a_reset_empty, $past(rst), !m_tvalid)
  `LRC_ASSERT_IMP(a_ready_free, !m_tvalid || m_tready, s_tready)
  `LRC_ASSERT_NEXT(a_cfg_readback, wr_min, rd_other || (prdata[19:0] == $past(pwdata[19:0])))

endmodule

bind lidar_return_to_cartesian_unit lrc_checker u_lrc_checker (.*);
`default_nettype wire
